// ===== hdl/epht_pkg.sv =====
package epht_pkg;

	localparam int TIME_W        = 64;
	localparam int STATUS_W      = 32;
	localparam int CNT_W         = 32;
	localparam int BIN_OUT_W     = 7;
	localparam int FUNC_W        = 3;

	localparam int BIN_US        = 2000;
	localparam int BIN_US_W      = 11;
	localparam int RATIO_SCALE   = 10;

	localparam int DIV_STEP_BITS = 8;
	localparam int TIME_STEPS    = TIME_W / DIV_STEP_BITS;
	localparam int TIME_STEP_W   = $clog2(TIME_STEPS);

	localparam logic [FUNC_W-1:0] FUNC_GOOD    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ERROR   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_SENT    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_REPORT  = 3'd4;

endpackage

// ===== hdl/event_phase_histogram_tally_unit.sv =====
// channel   dir  handshake                 payload
// event     in   start & !busy             func, time_us, status_word
// report    out  done, one cycle, no stall good_count .. ratio_tenths
//
// timeout and sent words only bump their counter and leave busy low; good and
// error words run the phase divider at 8 bits a cycle, then one bin read and one
// bin write. a report runs the bin scan through the ram read port, one multiply,
// then the ratio divider at one bit a cycle (DW = 42 at 96 bins); with no marks
// a report goes straight to the finish state. done rises as busy falls. after
// reset busy holds while the bin ram is cleared. results cannot be held off by
// the receiver.
module event_phase_histogram_tally_unit
	import epht_pkg::*;
#(
	parameter int BIN_COUNT = 96
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FUNC_W-1:0]    func,
	input  logic [TIME_W-1:0]    time_us,
	input  logic [STATUS_W-1:0]  status_word,
	output logic                 done,
	output logic [CNT_W-1:0]     good_count,
	output logic [CNT_W-1:0]     error_count,
	output logic [CNT_W-1:0]     timeout_count,
	output logic [CNT_W-1:0]     sent_count,
	output logic [STATUS_W-1:0]  last_good_status,
	output logic [STATUS_W-1:0]  last_error_status,
	output logic [CNT_W-1:0]     mark_total,
	output logic [BIN_OUT_W-1:0] peak_bin,
	output logic [CNT_W-1:0]     peak_value,
	output logic [BIN_OUT_W-1:0] runner_bin,
	output logic [CNT_W-1:0]     runner_value,
	output logic [CNT_W-1:0]     ratio_tenths
);

	localparam int IW        = $clog2(BIN_COUNT);
	localparam int RATIO_MUL = BIN_COUNT * RATIO_SCALE;
	localparam int MW        = $clog2(RATIO_MUL + 1);
	localparam int DW        = CNT_W + MW;
	localparam int DCW       = $clog2(DW);

	localparam logic [IW:0]  BINS      = (IW+1)'(BIN_COUNT);
	localparam logic [IW:0]  BINS_LAST = (IW+1)'(BIN_COUNT - 1);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(DW - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PHASE,
		ST_BIN_READ,
		ST_BIN_WRITE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]    good_q, error_q, timeout_q, sent_q, marks_q;
	logic [STATUS_W-1:0] good_st_q, error_st_q;
	logic                done_q;

	logic [TIME_W-1:0]      t_q;
	logic [BIN_US_W-1:0]    r_q;
	logic [IW-1:0]          idx_q;
	logic [TIME_STEP_W-1:0] tstep_q;
	logic [IW:0]            cnt_q;
	logic                   rd_valid_s1;
	logic [IW-1:0]          rd_idx_s1;

	logic [CNT_W-1:0] pk_q, pk2_q;
	logic [IW-1:0]    pki_q, pk2i_q;
	logic [DW-1:0]    dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [DCW-1:0]   dcnt_q;
	logic [CNT_W-1:0] ratio_q;

	logic                we;
	logic [IW-1:0]       waddr, raddr;
	logic [CNT_W-1:0]    wdata, rdata;

	logic [BIN_US_W-1:0] r_c;
	logic [IW-1:0]       q_c;
	logic [BIN_US_W:0]   r_ext;
	logic [IW:0]         q_ext;
	logic                r_ge;

	logic [CNT_W:0]      rem_sh;
	logic                rem_ge;

	logic [IW+BIN_OUT_W-1:0] pki_ext, pk2i_ext;

	epht_ram #(
		.WIDTH(CNT_W),
		.DEPTH(BIN_COUNT)
	) u_bins (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// floor(t / 2000) mod BIN_COUNT, eight bits per cycle
	always_comb begin
		r_c = r_q;
		q_c = idx_q;
		r_ext = '0;
		q_ext = '0;
		r_ge = 1'b0;
		for (int k = 0; k < DIV_STEP_BITS; k++) begin
			r_ext = {r_c, t_q[TIME_W-1-k]};
			r_ge = r_ext >= (BIN_US_W+1)'(BIN_US);
			if (r_ge) begin
				r_ext = r_ext - (BIN_US_W+1)'(BIN_US);
			end
			r_c = r_ext[BIN_US_W-1:0];
			q_ext = {q_c, r_ge};
			if (q_ext >= BINS) begin
				q_ext = q_ext - BINS;
			end
			q_c = q_ext[IW-1:0];
		end
	end

	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign rem_ge = rem_sh >= {1'b0, marks_q};

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = rdata + CNT_W'(1);
		raddr = idx_q;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = cnt_q[IW-1:0];
				wdata = '0;
			end
			ST_BIN_WRITE: begin
				we = 1'b1;
			end
			ST_SCAN: begin
				raddr = cnt_q[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			good_q <= '0;
			error_q <= '0;
			timeout_q <= '0;
			sent_q <= '0;
			marks_q <= '0;
			good_st_q <= '0;
			error_st_q <= '0;
			done_q <= 1'b0;
			cnt_q <= '0;
			tstep_q <= '0;
			dcnt_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			if (rd_valid_s1) begin
				if (rdata > pk_q) begin
					pk2_q <= pk_q;
					pk2i_q <= pki_q;
					pk_q <= rdata;
					pki_q <= rd_idx_s1;
				end else if (rdata > pk2_q) begin
					pk2_q <= rdata;
					pk2i_q <= rd_idx_s1;
				end
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + (IW+1)'(1);
					if (cnt_q == BINS_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						t_q <= time_us;
						r_q <= '0;
						idx_q <= '0;
						tstep_q <= '0;
						cnt_q <= '0;
						pk_q <= '0;
						pk2_q <= '0;
						pki_q <= '0;
						pk2i_q <= '0;
						dvd_q <= '0;
						rem_q <= '0;
						dcnt_q <= '0;
						case (func)
							FUNC_GOOD: begin
								good_q <= good_q + CNT_W'(1);
								good_st_q <= status_word;
								marks_q <= marks_q + CNT_W'(1);
								state_q <= ST_PHASE;
							end
							FUNC_ERROR: begin
								error_q <= error_q + CNT_W'(1);
								error_st_q <= status_word;
								marks_q <= marks_q + CNT_W'(1);
								state_q <= ST_PHASE;
							end
							FUNC_TIMEOUT: begin
								timeout_q <= timeout_q + CNT_W'(1);
							end
							FUNC_SENT: begin
								sent_q <= sent_q + CNT_W'(1);
							end
							FUNC_REPORT: begin
								state_q <= (marks_q == '0) ? ST_FINISH : ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PHASE: begin
					t_q <= t_q << DIV_STEP_BITS;
					r_q <= r_c;
					idx_q <= q_c;
					tstep_q <= tstep_q + TIME_STEP_W'(1);
					if (tstep_q == TIME_STEP_W'(TIME_STEPS - 1)) begin
						state_q <= ST_BIN_READ;
					end
				end
				ST_BIN_READ: begin
					state_q <= ST_BIN_WRITE;
				end
				ST_BIN_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (cnt_q == BINS) begin
						state_q <= ST_MUL;
					end else begin
						rd_valid_s1 <= 1'b1;
						rd_idx_s1 <= cnt_q[IW-1:0];
						cnt_q <= cnt_q + (IW+1)'(1);
					end
				end
				ST_MUL: begin
					dvd_q <= DW'(pk_q) * DW'(RATIO_MUL);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_ge ? CNT_W'(rem_sh - {1'b0, marks_q}) : rem_sh[CNT_W-1:0];
					dvd_q <= {dvd_q[DW-2:0], rem_ge};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DIV_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					ratio_q <= (|dvd_q[DW-1:CNT_W]) ? '1 : dvd_q[CNT_W-1:0];
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pki_ext  = (IW+BIN_OUT_W)'(pki_q);
	assign pk2i_ext = (IW+BIN_OUT_W)'(pk2i_q);

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign good_count        = good_q;
	assign error_count       = error_q;
	assign timeout_count     = timeout_q;
	assign sent_count        = sent_q;
	assign last_good_status  = good_st_q;
	assign last_error_status = error_st_q;
	assign mark_total        = marks_q;
	assign peak_bin          = pki_ext[BIN_OUT_W-1:0];
	assign peak_value        = pk_q;
	assign runner_bin        = pk2i_ext[BIN_OUT_W-1:0];
	assign runner_value      = pk2_q;
	assign ratio_tenths      = ratio_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_REPORT) |=> busy)
		else $error("report did not occupy the block");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIN_READ) |-> ({1'b0, idx_q} < BINS))
		else $error("phase bin out of range");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIN_WRITE) |-> $past(state_q == ST_BIN_READ))
		else $error("bin write without its read");

	a_no_peak_without_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(done && marks_q == '0) |-> (pk_q == '0 && ratio_q == '0))
		else $error("peak reported with no marks");
`endif

endmodule

// ===== hdl/epht_ram.sv =====
module epht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
